### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// shared data type and width for the heap sort engine
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

endpackage

### design/hse_ram.sv
// ----------------------------------------------------------------------------
// hse_ram
// heap store: one write port and one registered read port
// ----------------------------------------------------------------------------
module hse_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  hse_pkg::data_t  wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output hse_pkg::data_t  rd_data
);
	import hse_pkg::*;

	data_t mem_q [DEPTH];
	data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine
// batch sorter over a 1-based binary max-heap held in a single store
// ----------------------------------------------------------------------------
// Values are loaded one transfer per cycle until a transfer with s_tlast set;
// values beyond MAX_ELEMENTS are dropped and m_tuser flags every result of that
// batch. The block then sorts in place with one signed comparator and one
// store read port under a small sequencer: each sift-down level passes through
// S_CHK, S_RDR and S_CMP, every sift starts with S_FETCH, or S_X_RD1 and
// S_X_RD2, then S_GRAB, and each result goes through S_O_RD, S_O_LD and S_O_WAIT,
// held there until m_tready is high. The single registered read port of the store
// sets this sequence; s_tready stays low from the last load until the final result,
// which carries m_tlast, has been taken.
`include "assert_macros.svh"

module heap_sort_engine #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // sorted_value[31:0]
	output logic        m_tlast,   // end_of_run
	output logic        m_tuser    // overflow
);
	import hse_pkg::*;

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [3:0] {
		S_LOAD,
		S_FETCH,
		S_X_RD1,
		S_X_RD2,
		S_GRAB,
		S_CHK,
		S_RDR,
		S_CMP,
		S_O_RD,
		S_O_LD,
		S_O_WAIT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic            ovf_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   node_q;
	logic [CW-1:0]   size_q;
	logic            extract_q;
	data_t           cur_q;
	data_t           big_q;
	logic [CW:0]     bi_q;
	logic [AW-1:0]   oi_q;
	logic            m_tvalid_q;
	data_t           m_tdata_q;
	logic            m_tlast_q;
	logic            m_tuser_q;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	data_t           wr_data;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	data_t           rd_data;

	data_t           cmp_a;
	data_t           cmp_b;
	logic            cmp_gt;

	logic [CW:0]     left_w;
	logic [CW:0]     right_w;
	logic [CW:0]     size_ext;
	logic [CW:0]     node_ext;
	logic            has_right;
	logic            take_right;
	logic [CW:0]     nbi;
	data_t           nbig;
	logic            in_xfer;
	logic            room;
	logic [CW-1:0]   n_new;
	logic [AW-1:0]   node_addr;

	hse_ram #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_xfer    = s_tvalid && s_tready;
	assign room       = (cnt_q < CW'(MAX_ELEMENTS));
	assign n_new      = room ? (cnt_q + CW'(1)) : cnt_q;
	assign left_w     = {node_q, 1'b0};
	assign right_w    = left_w + (CW+1)'(1);
	assign size_ext   = {1'b0, size_q};
	assign node_ext   = {1'b0, node_q};
	assign node_addr  = AW'(node_q - CW'(1));
	assign has_right  = (right_w <= size_ext);

	// shared signed comparator
	assign cmp_gt     = (cmp_a > cmp_b);
	assign take_right = has_right && cmp_gt;
	assign nbi        = take_right ? right_w : bi_q;
	assign nbig       = take_right ? rd_data : big_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = node_addr;
		wr_data = cur_q;
		rd_en   = 1'b0;
		rd_addr = node_addr;
		cmp_a   = rd_data;
		cmp_b   = cur_q;
		case (state_q)
			S_LOAD: begin
				wr_en   = in_xfer && room;
				wr_addr = AW'(cnt_q);
				wr_data = data_t'(s_tdata);
			end
			S_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = AW'(k_q - CW'(1));
			end
			S_X_RD1: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_X_RD2: begin
				rd_en   = 1'b1;
				rd_addr = AW'(k_q - CW'(1));
				wr_en   = 1'b1;
				wr_addr = AW'(k_q - CW'(1));
				wr_data = rd_data;
			end
			S_CHK: begin
				if (left_w > size_ext) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(left_w - (CW+1)'(1));
				end
			end
			S_RDR: begin
				rd_en   = has_right;
				rd_addr = AW'(right_w - (CW+1)'(1));
			end
			S_CMP: begin
				cmp_b = big_q;
				wr_en = 1'b1;
				if (nbi != node_ext) begin
					wr_data = nbig;
				end
			end
			S_O_RD: begin
				rd_en   = 1'b1;
				rd_addr = oi_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			k_q        <= '0;
			node_q     <= '0;
			size_q     <= '0;
			extract_q  <= 1'b0;
			oi_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						cnt_q <= n_new;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							extract_q <= 1'b0;
							oi_q      <= '0;
							if (n_new >= CW'(2)) begin
								k_q     <= n_new >> 1;
								state_q <= S_FETCH;
							end else begin
								state_q <= S_O_RD;
							end
						end
					end
				end
				S_FETCH: begin
					state_q <= S_GRAB;
				end
				S_X_RD1: begin
					state_q <= S_X_RD2;
				end
				S_X_RD2: begin
					state_q <= S_GRAB;
				end
				S_GRAB: begin
					cur_q   <= rd_data;
					node_q  <= extract_q ? CW'(1) : k_q;
					size_q  <= extract_q ? (k_q - CW'(1)) : cnt_q;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (left_w > size_ext) begin
						if (!extract_q) begin
							if (k_q == CW'(1)) begin
								extract_q <= 1'b1;
								k_q       <= cnt_q;
								state_q   <= S_X_RD1;
							end else begin
								k_q     <= k_q - CW'(1);
								state_q <= S_FETCH;
							end
						end else begin
							k_q <= k_q - CW'(1);
							state_q <= (k_q > CW'(2)) ? S_X_RD1 : S_O_RD;
						end
					end else begin
						state_q <= S_RDR;
					end
				end
				S_RDR: begin
					big_q   <= cmp_gt ? rd_data : cur_q;
					bi_q    <= cmp_gt ? left_w : node_ext;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (nbi == node_ext) begin
						if (!extract_q) begin
							if (k_q == CW'(1)) begin
								extract_q <= 1'b1;
								k_q       <= cnt_q;
								state_q   <= S_X_RD1;
							end else begin
								k_q     <= k_q - CW'(1);
								state_q <= S_FETCH;
							end
						end else begin
							k_q <= k_q - CW'(1);
							state_q <= (k_q > CW'(2)) ? S_X_RD1 : S_O_RD;
						end
					end else begin
						node_q  <= CW'(nbi);
						state_q <= S_CHK;
					end
				end
				S_O_RD: begin
					state_q <= S_O_LD;
				end
				S_O_LD: begin
					m_tdata_q  <= rd_data;
					m_tlast_q  <= (CW'(oi_q) == (cnt_q - CW'(1)));
					m_tuser_q  <= ovf_q;
					m_tvalid_q <= 1'b1;
					state_q    <= S_O_WAIT;
				end
				S_O_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (m_tlast_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							oi_q    <= oi_q + AW'(1);
							state_q <= S_O_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_LOAD);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	`ASSERT_ALWAYS(a_no_load_during_output, !(s_tready && m_tvalid), "load while result pending")
	`ASSERT_ALWAYS(a_count_in_range, cnt_q <= CW'(MAX_ELEMENTS), "element count past depth")
	`ASSERT_ALWAYS(a_ovf_only_when_full, !ovf_q || (cnt_q == CW'(MAX_ELEMENTS)), "overflow without full store")
	`ASSERT_NEXT(a_reload_after_run, m_tvalid && m_tready && m_tlast, s_tready && (cnt_q == '0), "no return to load after run")

endmodule

### sim/sort_checker.sv
// ----------------------------------------------------------------------------
// sort_checker
// watches both streams of the heap sort engine, predicts each sorted batch
// from the accepted input transfers and compares every output transfer
// ----------------------------------------------------------------------------
module sort_checker #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic        s_tlast,   // is_last
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // sorted_value[31:0]
	input  logic        m_tlast,   // end_of_run
	input  logic        m_tuser,   // overflow
	output int          fail_count,
	output int          pending,
	output int          result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import hse_pkg::*;

	typedef struct packed {
		data_t value;
		logic  end_of_run;
		logic  overflow;
	} sorted_item_t;

	sorted_item_t sorted_expect[$];
	sorted_item_t want;
	data_t        heap_store [1:MAX_ELEMENTS];
	int           element_count;
	logic         overflow_seen;
	int           mismatches;
	int           results_seen;

	function automatic void swap_nodes(int p, int q);
		data_t tmp;
		tmp = heap_store[p];
		heap_store[p] = heap_store[q];
		heap_store[q] = tmp;
	endfunction

	function automatic void sift_down(int node, int size);
		int   left;
		int   right;
		int   big;
		logic done;
		done = 1'b0;
		while (!done) begin
			left  = 2 * node;
			right = left + 1;
			big   = node;
			if (left <= size && heap_store[left] > heap_store[big])
				big = left;
			if (right <= size && heap_store[right] > heap_store[big])
				big = right;
			if (big == node) begin
				done = 1'b1;
			end else begin
				swap_nodes(node, big);
				node = big;
			end
		end
	endfunction

	function automatic void predict_sorted_batch();
		int           n;
		sorted_item_t item;
		n = element_count;
		for (int k = n / 2; k >= 1; k--)
			sift_down(k, n);
		for (int k = n; k >= 2; k--) begin
			swap_nodes(1, k);
			sift_down(1, k - 1);
		end
		for (int k = 1; k <= n; k++) begin
			item.value      = heap_store[k];
			item.end_of_run = (k == n);
			item.overflow   = overflow_seen;
			sorted_expect.push_back(item);
		end
		element_count = 0;
		overflow_seen = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_expect.delete();
			element_count = 0;
			overflow_seen = 1'b0;
			mismatches    = 0;
			results_seen  = 0;
			fail_count   <= 0;
			pending      <= 0;
			result_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (element_count < MAX_ELEMENTS) begin
					element_count++;
					heap_store[element_count] = s_tdata;
				end else begin
					overflow_seen = 1'b1;
				end
				if (s_tlast)
					predict_sorted_batch();
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (sorted_expect.size() == 0) begin
					$error("unexpected result transfer: sorted_value %0d",
						$signed(m_tdata));
					mismatches++;
				end else begin
					want = sorted_expect.pop_front();
					if (m_tdata !== want.value) begin
						$error("sorted_value: expected %0d, actual %0d",
							want.value, $signed(m_tdata));
						mismatches++;
					end
					if (m_tlast !== want.end_of_run) begin
						$error("end_of_run: expected %0b, actual %0b",
							want.end_of_run, m_tlast);
						mismatches++;
					end
					if (m_tuser !== want.overflow) begin
						$error("overflow: expected %0b, actual %0b",
							want.overflow, m_tuser);
						mismatches++;
					end
				end
			end
			fail_count   <= mismatches;
			pending      <= sorted_expect.size();
			result_count <= results_seen;
		end
	end

endmodule

### sim/tb_heap_sort_engine.sv
// ----------------------------------------------------------------------------
// tb_heap_sort_engine
// drives batches of signed values into the heap sort engine with random
// gaps and back-pressure; a checker beside the block predicts and compares
// the ascending output of every batch, including batches that overflow
// ----------------------------------------------------------------------------
module tb_heap_sort_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import hse_pkg::*;

	localparam int    MAX_ELEMENTS = 64;
	localparam int    STALL_LIMIT  = 20000;
	localparam int    DRAIN_CYCLES = 64;
	localparam data_t VAL_MIN      = 32'sh80000000;
	localparam data_t VAL_MAX      = 32'sh7fffffff;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // value[31:0]
	logic        s_tlast;   // is_last
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // sorted_value[31:0]
	logic        m_tlast;   // end_of_run
	logic        m_tuser;   // overflow

	int    fail_count;
	int    pending;
	int    result_count;
	int    stall_cycles = 0;
	int    items_sent = 0;
	int    batches_sent = 0;
	int    overflow_batches = 0;
	bit    no_idle = 1'b0;
	data_t batch_vals[$];

	heap_sort_engine #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	sort_checker #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// output back-pressure in random bursts
	initial begin
		int span;
		forever begin
			span = $urandom_range(1, 16);
			if (!no_idle && $urandom_range(0, 2) == 0)
				m_tready <= 1'b0;
			else
				m_tready <= 1'b1;
			repeat (span) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic data_t random_value();
		case ($urandom_range(0, 3))
			0: random_value = $urandom_range(0, 8) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: random_value = VAL_MIN;
					1: random_value = VAL_MAX;
					2: random_value = '0;
					default: random_value = '1;
				endcase
			end
			default: random_value = $urandom;
		endcase
	endfunction

	task automatic send_value(input data_t v, input logic last);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_batch();
		for (int i = 0; i < batch_vals.size(); i++)
			send_value(batch_vals[i], i == batch_vals.size() - 1);
		batches_sent++;
		if (batch_vals.size() > MAX_ELEMENTS)
			overflow_batches++;
	endtask

	task automatic send_random_batch(input int len);
		batch_vals.delete();
		repeat (len) batch_vals.push_back(random_value());
		send_batch();
	endtask

	initial begin
		bit overflow_done;
		overflow_done = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element, then the two extremes, then a mix with repeated values
		batch_vals = '{VAL_MAX};
		send_batch();
		batch_vals = '{VAL_MAX, VAL_MIN};
		send_batch();
		batch_vals = '{32'sd0, -32'sd1, 32'sd1, VAL_MAX, VAL_MIN, VAL_MAX, 32'sd0, -32'sd1};
		send_batch();
		// already ascending, then ascending negative values, then all equal
		batch_vals.delete();
		for (int i = 1; i <= 5; i++) batch_vals.push_back(i);
		send_batch();
		batch_vals.delete();
		for (int i = 5; i >= 1; i--) batch_vals.push_back(-i);
		send_batch();
		batch_vals = '{32'sd42, 32'sd42, 32'sd42};
		send_batch();

		while (items_sent < 180) begin
			if (!overflow_done && items_sent >= 70) begin
				// store fills up, extra values and the last one are dropped
				send_random_batch(MAX_ELEMENTS + $urandom_range(1, 3));
				overflow_done = 1'b1;
			end else begin
				send_random_batch($urandom_range(1, 12));
			end
			if (items_sent >= 150)
				no_idle = 1'b1;
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d batches, %0d input transfers, %0d batch(es) with dropped values",
			batches_sent, items_sent, overflow_batches);
		$display("checked %0d sorted output transfers, %0d mismatches",
			result_count, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### heap_sort_engine.f
+incdir+design
design/hse_pkg.sv
design/hse_ram.sv
design/heap_sort_engine.sv
sim/sort_checker.sv
sim/tb_heap_sort_engine.sv
